FILE: hdl/acbt_pkg.sv
// acbt_pkg: shared types and constants for the alphanumeric/CJK byte tokenizer.
// No dependencies; imported by every module of the block.
package acbt_pkg;

  localparam int TOKEN_START_W = 20;
  localparam int TOKEN_LEN_W   = 16;
  localparam int CP_W          = 21;

  localparam logic [1:0] CFG_LOWERCASE = 2'd0;
  localparam logic [1:0] CFG_MAX_LEN   = 2'd1;

  localparam logic [TOKEN_LEN_W-1:0] MAX_LEN_RESET = 16'd255;

  localparam logic [CP_W-1:0] CJK_A_LO = 21'h04E00;
  localparam logic [CP_W-1:0] CJK_A_HI = 21'h09FFF;
  localparam logic [CP_W-1:0] CJK_B_LO = 21'h03400;
  localparam logic [CP_W-1:0] CJK_B_HI = 21'h04DBF;
  localparam logic [CP_W-1:0] CJK_C_LO = 21'h20000;
  localparam logic [CP_W-1:0] CJK_C_HI = 21'h2A6DF;
  localparam logic [CP_W-1:0] CJK_D_LO = 21'h2A700;
  localparam logic [CP_W-1:0] CJK_D_HI = 21'h2EBEF;
  localparam logic [CP_W-1:0] CJK_E_LO = 21'h30000;
  localparam logic [CP_W-1:0] CJK_E_HI = 21'h3134A;

  localparam logic [CP_W-1:0] CP_3BYTE = 21'h00800;
  localparam logic [CP_W-1:0] CP_4BYTE = 21'h10000;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_SEQ  = 2'd2
  } scan_mode_t;

  typedef enum logic [2:0] {
    BND_NONE  = 3'd0,
    BND_A0_BF = 3'd1,
    BND_80_9F = 3'd2,
    BND_90_BF = 3'd3,
    BND_80_8F = 3'd4
  } bounds_t;

  typedef struct packed {
    logic [CP_W-1:0] acc;
    logic [1:0]      left;
    bounds_t         bounds;
  } seq_state_t;

  typedef struct packed {
    logic       trail_ok;
    seq_state_t trail_next;
    logic       trail_done;
    logic       cjk_hit;
    logic [2:0] cjk_len;
    logic       lead_ok;
    seq_state_t lead_next;
  } dec_t;

endpackage

FILE: hdl/alnum_cjk_byte_tokenizer.sv
// alnum_cjk_byte_tokenizer: top level; input register, config registers, scan core.
// Result path: input register, then result register; either can be held by out_stall.
// Throughput: one item per cycle unless out_stall holds; one scan-state pass per byte.
// Reset (rst, synchronous): empties both registers, clears scan state, config to defaults.
// Depends on acbt_pkg, acbt_core, acbt_utf8_dec.
module alnum_cjk_byte_tokenizer
  import acbt_pkg::*;
#(
  parameter longint unsigned MAX_TEXT_BYTES   = 1048576,
  parameter int unsigned     LEN_COUNTER_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [1:0]               cfg_index,
  input  logic [TOKEN_LEN_W-1:0]   cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_byte,
  output logic                     token_valid,
  output logic [TOKEN_START_W-1:0] token_start,
  output logic [TOKEN_LEN_W-1:0]   token_length,
  output logic                     token_kind,
  output logic                     end_of_text
);

  logic                   lowercase_enable;
  logic [TOKEN_LEN_W-1:0] max_token_len;
  logic                   in_q_valid;
  logic [7:0]             in_q_byte;
  logic                   in_q_last;
  logic                   advance;
  logic                   in_take;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowercase_enable <= 1'b0;
      max_token_len    <= MAX_LEN_RESET;
      in_q_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_LOWERCASE: lowercase_enable <= cfg_data[0];
          CFG_MAX_LEN:   max_token_len    <= cfg_data;
          default: ;
        endcase
      end
      if (in_take) begin
        in_q_valid <= 1'b1;
      end else if (advance) begin
        in_q_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_byte <= data_byte;
      in_q_last <= last_byte;
    end
  end

  acbt_core #(
    .MAX_TEXT_BYTES   (MAX_TEXT_BYTES),
    .LEN_COUNTER_BITS (LEN_COUNTER_BITS)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .item_valid       (in_q_valid),
    .byte_in          (in_q_byte),
    .last_in          (in_q_last),
    .lowercase_enable (lowercase_enable),
    .max_token_len    (max_token_len),
    .out_valid        (out_valid),
    .out_byte         (out_byte),
    .token_valid      (token_valid),
    .token_start      (token_start),
    .token_length     (token_length),
    .token_kind       (token_kind),
    .end_of_text      (end_of_text)
  );

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    (in_q_valid && !advance) |=> in_q_valid)
    else $error("buffered item dropped while output stalled");

  a_no_token_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !token_valid) |->
      (token_start == '0 && token_length == '0 && !token_kind))
    else $error("token fields set without a token");

  a_len_clipped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_valid) |-> (token_length <= max_token_len))
    else $error("token length exceeds configured maximum");

  a_cjk_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && token_valid && token_kind) |-> (token_length <= 16'd4))
    else $error("ideograph token longer than four bytes");

endmodule

FILE: hdl/acbt_utf8_dec.sv
// acbt_utf8_dec: combinational UTF-8 step decoder (lead and trail byte checks, CJK test).
// Depends on acbt_pkg.
module acbt_utf8_dec
  import acbt_pkg::*;
(
  input  logic [7:0] byte_in,
  input  seq_state_t seq,
  output dec_t       dec
);

  logic            fits;
  logic [CP_W-1:0] acc_next;

  always_comb begin
    case (seq.bounds)
      BND_A0_BF: fits = (byte_in >= 8'hA0) && (byte_in <= 8'hBF);
      BND_80_9F: fits = (byte_in >= 8'h80) && (byte_in <= 8'h9F);
      BND_90_BF: fits = (byte_in >= 8'h90) && (byte_in <= 8'hBF);
      BND_80_8F: fits = (byte_in >= 8'h80) && (byte_in <= 8'h8F);
      default:   fits = (byte_in >= 8'h80) && (byte_in <= 8'hBF);
    endcase
  end

  assign acc_next = {seq.acc[CP_W-7:0], byte_in[5:0]};

  always_comb begin
    dec.trail_ok          = fits && (seq.left != 2'd0);
    dec.trail_next.acc    = acc_next;
    dec.trail_next.left   = seq.left - 2'd1;
    dec.trail_next.bounds = BND_NONE;
    dec.trail_done        = (seq.left == 2'd1);
    dec.cjk_hit = ((acc_next >= CJK_A_LO) && (acc_next <= CJK_A_HI)) ||
                  ((acc_next >= CJK_B_LO) && (acc_next <= CJK_B_HI)) ||
                  ((acc_next >= CJK_C_LO) && (acc_next <= CJK_C_HI)) ||
                  ((acc_next >= CJK_D_LO) && (acc_next <= CJK_D_HI)) ||
                  ((acc_next >= CJK_E_LO) && (acc_next <= CJK_E_HI));
    if (acc_next < CP_3BYTE) begin
      dec.cjk_len = 3'd2;
    end else if (acc_next < CP_4BYTE) begin
      dec.cjk_len = 3'd3;
    end else begin
      dec.cjk_len = 3'd4;
    end

    dec.lead_ok          = 1'b0;
    dec.lead_next.acc    = '0;
    dec.lead_next.left   = 2'd0;
    dec.lead_next.bounds = BND_NONE;
    if ((byte_in >= 8'hC2) && (byte_in <= 8'hDF)) begin
      dec.lead_ok        = 1'b1;
      dec.lead_next.acc  = CP_W'(byte_in[4:0]);
      dec.lead_next.left = 2'd1;
    end else if ((byte_in >= 8'hE0) && (byte_in <= 8'hEF)) begin
      dec.lead_ok        = 1'b1;
      dec.lead_next.acc  = CP_W'(byte_in[3:0]);
      dec.lead_next.left = 2'd2;
      if (byte_in == 8'hE0) begin
        dec.lead_next.bounds = BND_A0_BF;
      end else if (byte_in == 8'hED) begin
        dec.lead_next.bounds = BND_80_9F;
      end
    end else if ((byte_in >= 8'hF0) && (byte_in <= 8'hF4)) begin
      dec.lead_ok        = 1'b1;
      dec.lead_next.acc  = CP_W'(byte_in[2:0]);
      dec.lead_next.left = 2'd3;
      if (byte_in == 8'hF0) begin
        dec.lead_next.bounds = BND_90_BF;
      end else if (byte_in == 8'hF4) begin
        dec.lead_next.bounds = BND_80_8F;
      end
    end
  end

endmodule

FILE: hdl/acbt_core.sv
// acbt_core: scan state, run tracking, token build and the result register.
// Depends on acbt_pkg and acbt_utf8_dec.
module acbt_core
  import acbt_pkg::*;
#(
  parameter longint unsigned MAX_TEXT_BYTES   = 1048576,
  parameter int unsigned     LEN_COUNTER_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     item_valid,
  input  logic [7:0]               byte_in,
  input  logic                     last_in,
  input  logic                     lowercase_enable,
  input  logic [TOKEN_LEN_W-1:0]   max_token_len,
  output logic                     out_valid,
  output logic [7:0]               out_byte,
  output logic                     token_valid,
  output logic [TOKEN_START_W-1:0] token_start,
  output logic [TOKEN_LEN_W-1:0]   token_length,
  output logic                     token_kind,
  output logic                     end_of_text
);

  localparam int POS_W = $clog2(MAX_TEXT_BYTES);
  localparam logic [POS_W:0] POS_LIMIT = (POS_W+1)'(MAX_TEXT_BYTES);

  scan_mode_t                  mode, mode_next;
  logic [POS_W-1:0]            pos, pos_next;
  logic [POS_W-1:0]            run_start, run_start_next;
  logic [LEN_COUNTER_BITS-1:0] run_length, run_length_next;
  seq_state_t                  seq, seq_next;
  logic [POS_W-1:0]            seq_start, seq_start_next;

  dec_t                        dec;
  logic                        alnum_hit;
  logic [POS_W:0]              pos_inc;
  logic [LEN_COUNTER_BITS-1:0] rl_base;
  logic [7:0]                  echo;
  logic                        tok_v, tok_k;
  logic [POS_W-1:0]            tok_s;
  logic [31:0]                 tok_len_raw;
  logic [31:0]                 max_len32;
  logic [TOKEN_LEN_W-1:0]      tok_len_clip;
  logic [63:0]                 tok_s_wide;
  logic                        consumed;

  acbt_utf8_dec u_dec (
    .byte_in (byte_in),
    .seq     (seq),
    .dec     (dec)
  );

  assign alnum_hit = ((byte_in >= 8'h30) && (byte_in <= 8'h39)) ||
                     ((byte_in >= 8'h41) && (byte_in <= 8'h5A)) ||
                     ((byte_in >= 8'h61) && (byte_in <= 8'h7A));
  assign pos_inc  = {1'b0, pos} + 1'b1;

  always_comb begin
    mode_next       = mode;
    run_start_next  = run_start;
    run_length_next = run_length;
    seq_next        = seq;
    seq_start_next  = seq_start;
    echo            = byte_in;
    tok_v           = 1'b0;
    tok_k           = 1'b0;
    tok_s           = '0;
    tok_len_raw     = '0;
    consumed        = 1'b0;
    rl_base         = run_length;

    if (alnum_hit) begin
      if (lowercase_enable && (byte_in >= 8'h41) && (byte_in <= 8'h5A)) begin
        echo = byte_in + 8'h20;
      end
      if (mode != MODE_RUN) begin
        mode_next      = MODE_RUN;
        run_start_next = pos;
        rl_base        = '0;
      end
      run_length_next = (rl_base == '1) ? rl_base : rl_base + 1'b1;
      if (last_in) begin
        tok_v       = 1'b1;
        tok_s       = run_start_next;
        tok_len_raw = 32'(run_length_next);
      end
    end else begin
      if (mode == MODE_RUN) begin
        tok_v       = 1'b1;
        tok_s       = run_start;
        tok_len_raw = 32'(run_length);
        mode_next   = MODE_IDLE;
      end else if (mode == MODE_SEQ) begin
        if (dec.trail_ok) begin
          consumed = 1'b1;
          seq_next = dec.trail_next;
          if (dec.trail_done) begin
            mode_next = MODE_IDLE;
            if (dec.cjk_hit) begin
              tok_v       = 1'b1;
              tok_k       = 1'b1;
              tok_s       = seq_start;
              tok_len_raw = 32'(dec.cjk_len);
            end
          end
        end else begin
          mode_next = MODE_IDLE;
        end
      end
      if (!consumed && (mode_next == MODE_IDLE) && dec.lead_ok) begin
        mode_next      = MODE_SEQ;
        seq_next       = dec.lead_next;
        seq_start_next = pos;
      end
    end

    pos_next = (pos_inc >= POS_LIMIT) ? '0 : pos_inc[POS_W-1:0];

    if (last_in) begin
      mode_next       = MODE_IDLE;
      pos_next        = '0;
      run_start_next  = '0;
      run_length_next = '0;
      seq_next.acc    = '0;
      seq_next.left   = 2'd0;
      seq_next.bounds = BND_NONE;
      seq_start_next  = '0;
    end
  end

  assign max_len32    = 32'(max_token_len);
  assign tok_len_clip = (tok_len_raw < max_len32) ? tok_len_raw[TOKEN_LEN_W-1:0]
                                                  : max_token_len;
  assign tok_s_wide   = 64'(tok_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      pos        <= '0;
      run_start  <= '0;
      run_length <= '0;
      seq.acc    <= '0;
      seq.left   <= 2'd0;
      seq.bounds <= BND_NONE;
      seq_start  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= item_valid;
      end
      if (advance && item_valid) begin
        mode       <= mode_next;
        pos        <= pos_next;
        run_start  <= run_start_next;
        run_length <= run_length_next;
        seq        <= seq_next;
        seq_start  <= seq_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      out_byte     <= echo;
      token_valid  <= tok_v;
      token_start  <= tok_s_wide[TOKEN_START_W-1:0];
      token_length <= tok_v ? tok_len_clip : '0;
      token_kind   <= tok_k;
      end_of_text  <= last_in;
    end
  end

endmodule

FILE: test/alnum_cjk_byte_tokenizer_tb.sv
`timescale 1ns / 1ps
// alnum_cjk_byte_tokenizer_tb: self-checking bench for the alphanumeric/CJK byte tokenizer.
// A behavioral tokenizer predicts every result; UTF-8 text is driven with idles and stalls.
// Depends on acbt_pkg and alnum_cjk_byte_tokenizer.
module alnum_cjk_byte_tokenizer_tb;
  import acbt_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 6;

  // indexes past the two registers; writes there must be ignored
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  typedef struct {
    logic [7:0] b;
    logic       last;
    bit         drain_after;
  } text_item_t;

  typedef struct packed {
    logic [7:0]               echo;
    logic                     tok_valid;
    logic [TOKEN_START_W-1:0] tok_start;
    logic [TOKEN_LEN_W-1:0]   tok_len;
    logic                     tok_kind;
    logic                     eot;
  } scan_result_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [1:0]               cfg_index = CFG_LOWERCASE;
  logic [TOKEN_LEN_W-1:0]   cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic [7:0]               data_byte = '0;
  logic                     last_byte = 1'b0;
  logic                     out_stall = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic [7:0]               out_byte;
  logic                     token_valid;
  logic [TOKEN_START_W-1:0] token_start;
  logic [TOKEN_LEN_W-1:0]   token_length;
  logic                     token_kind;
  logic                     end_of_text;

  alnum_cjk_byte_tokenizer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .token_valid  (token_valid),
    .token_start  (token_start),
    .token_length (token_length),
    .token_kind   (token_kind),
    .end_of_text  (end_of_text)
  );

  always #4 clk = ~clk;

  text_item_t   byte_q[$];
  scan_result_t scan_q[$];
  int           bytes_queued   = 0;
  int           bytes_sent     = 0;
  int           errors         = 0;
  int           cycles         = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           hold_left      = 0;
  bit           hold_req       = 1'b0;
  bit           byte_taken     = 1'b0;
  bit           draining       = 1'b0;

  // tokenizer state and register copies
  logic                     lc_en        = 1'b0;
  logic [TOKEN_LEN_W-1:0]   max_len      = MAX_LEN_RESET;
  scan_mode_t               tk_mode      = MODE_IDLE;
  logic [TOKEN_START_W-1:0] tk_pos       = '0;
  logic [TOKEN_START_W-1:0] tk_run_start = '0;
  logic [TOKEN_LEN_W-1:0]   tk_run_len   = '0;
  logic [CP_W-1:0]          tk_cp        = '0;
  logic [1:0]               tk_left      = '0;
  bounds_t                  tk_bounds    = BND_NONE;
  logic [TOKEN_START_W-1:0] tk_seq_start = '0;

  function automatic bit is_word_byte(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic [TOKEN_LEN_W-1:0] clip_len(input logic [TOKEN_LEN_W-1:0] len);
    return (len < max_len) ? len : max_len;
  endfunction

  function automatic scan_result_t tokenize_byte(input logic [7:0] b, input logic last);
    scan_result_t r;
    logic         fits;
    logic         taken;
    r       = '0;
    r.echo  = b;
    r.eot   = last;
    taken   = 1'b0;
    if (is_word_byte(b)) begin
      if (lc_en && b >= 8'h41 && b <= 8'h5A) r.echo = b + 8'h20;
      if (tk_mode != MODE_RUN) begin
        tk_mode      = MODE_RUN;
        tk_run_start = tk_pos;
        tk_run_len   = '0;
      end
      if (tk_run_len != '1) tk_run_len++;
      if (last) begin
        r.tok_valid = 1'b1;
        r.tok_start = tk_run_start;
        r.tok_len   = clip_len(tk_run_len);
      end
    end else begin
      if (tk_mode == MODE_RUN) begin
        r.tok_valid = 1'b1;
        r.tok_start = tk_run_start;
        r.tok_len   = clip_len(tk_run_len);
        tk_mode     = MODE_IDLE;
      end else if (tk_mode == MODE_SEQ) begin
        case (tk_bounds)
          BND_A0_BF: fits = b >= 8'hA0 && b <= 8'hBF;
          BND_80_9F: fits = b >= 8'h80 && b <= 8'h9F;
          BND_90_BF: fits = b >= 8'h90 && b <= 8'hBF;
          BND_80_8F: fits = b >= 8'h80 && b <= 8'h8F;
          default:   fits = b >= 8'h80 && b <= 8'hBF;
        endcase
        if (fits && tk_left != 2'd0) begin
          taken     = 1'b1;
          tk_cp     = {tk_cp[CP_W-7:0], b[5:0]};
          tk_bounds = BND_NONE;
          tk_left--;
          if (tk_left == 2'd0) begin
            tk_mode = MODE_IDLE;
            if ((tk_cp >= CJK_A_LO && tk_cp <= CJK_A_HI) ||
                (tk_cp >= CJK_B_LO && tk_cp <= CJK_B_HI) ||
                (tk_cp >= CJK_C_LO && tk_cp <= CJK_C_HI) ||
                (tk_cp >= CJK_D_LO && tk_cp <= CJK_D_HI) ||
                (tk_cp >= CJK_E_LO && tk_cp <= CJK_E_HI)) begin
              r.tok_valid = 1'b1;
              r.tok_kind  = 1'b1;
              r.tok_start = tk_seq_start;
              r.tok_len   = clip_len(tk_cp < CP_3BYTE ? 16'd2 :
                                     tk_cp < CP_4BYTE ? 16'd3 : 16'd4);
            end
          end
        end else begin
          tk_mode = MODE_IDLE;
        end
      end
      // broken sequence falls through here and the byte is taken as fresh
      if (!taken && tk_mode == MODE_IDLE) begin
        if (b >= 8'hC2 && b <= 8'hDF) begin
          tk_mode      = MODE_SEQ;
          tk_left      = 2'd1;
          tk_cp        = {16'd0, b[4:0]};
          tk_bounds    = BND_NONE;
          tk_seq_start = tk_pos;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          tk_mode      = MODE_SEQ;
          tk_left      = 2'd2;
          tk_cp        = {17'd0, b[3:0]};
          tk_bounds    = (b == 8'hE0) ? BND_A0_BF : (b == 8'hED) ? BND_80_9F : BND_NONE;
          tk_seq_start = tk_pos;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          tk_mode      = MODE_SEQ;
          tk_left      = 2'd3;
          tk_cp        = {18'd0, b[2:0]};
          tk_bounds    = (b == 8'hF0) ? BND_90_BF : (b == 8'hF4) ? BND_80_8F : BND_NONE;
          tk_seq_start = tk_pos;
        end
      end
    end
    tk_pos++;
    if (last) begin
      tk_mode      = MODE_IDLE;
      tk_pos       = '0;
      tk_run_start = '0;
      tk_run_len   = '0;
      tk_cp        = '0;
      tk_left      = '0;
      tk_bounds    = BND_NONE;
      tk_seq_start = '0;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // ---------------- stimulus helpers ----------------
  task automatic push_byte(input logic [7:0] b);
    text_item_t it;
    it.b           = b;
    it.last        = 1'b0;
    it.drain_after = 1'b0;
    byte_q.push_back(it);
    bytes_queued++;
  endtask

  task automatic push_cp(input logic [CP_W-1:0] cp);
    if (cp < 21'h80) begin
      push_byte(cp[7:0]);
    end else if (cp < CP_3BYTE) begin
      push_byte({3'b110, cp[10:6]});
      push_byte({2'b10, cp[5:0]});
    end else if (cp < CP_4BYTE) begin
      push_byte({4'b1110, cp[15:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end else begin
      push_byte({5'b11110, cp[20:18]});
      push_byte({2'b10, cp[17:12]});
      push_byte({2'b10, cp[11:6]});
      push_byte({2'b10, cp[5:0]});
    end
  endtask

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(61);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 36) return 8'(8'h41 + r - 10);
    return 8'(8'h61 + r - 36);
  endfunction

  function automatic logic [7:0] rand_sep();
    logic [7:0] b;
    if ($urandom_range(1) == 0) return 8'h20;
    do b = 8'($urandom_range(127)); while (is_word_byte(b));
    return b;
  endfunction

  function automatic logic [CP_W-1:0] rand_cjk();
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
    case ($urandom_range(4))
      0:       begin lo = CJK_A_LO; hi = CJK_A_HI; end
      1:       begin lo = CJK_B_LO; hi = CJK_B_HI; end
      2:       begin lo = CJK_C_LO; hi = CJK_C_HI; end
      3:       begin lo = CJK_D_LO; hi = CJK_D_HI; end
      default: begin lo = CJK_E_LO; hi = CJK_E_HI; end
    endcase
    // edges and just outside them
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      2:       return lo - 1'b1;
      3:       return hi + 1'b1;
      default: return CP_W'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic logic [CP_W-1:0] rand_cp();
    logic [CP_W-1:0] cp;
    case ($urandom_range(2))
      0:       cp = CP_W'($urandom_range(21'h7FF, 21'h80));
      1:       cp = CP_W'($urandom_range(21'hFFFF, 21'h800));
      default: cp = CP_W'($urandom_range(21'h10FFFF, 21'h10000));
    endcase
    if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = 21'hE000;
    return cp;
  endfunction

  function automatic logic [7:0] rand_trail();
    return 8'($urandom_range(8'hBF, 8'h80));
  endfunction

  task automatic push_broken();
    case ($urandom_range(5))
      0: begin
        // lead byte with at most one trail; the next piece may cut it off
        push_byte(8'($urandom_range(8'hF4, 8'hC2)));
        if ($urandom_range(1) == 0) push_byte(rand_trail());
      end
      1: begin
        push_byte(8'hC0 | 8'($urandom_range(1)));
        push_byte(rand_trail());
      end
      2: begin
        push_byte(8'hE0);
        push_byte(8'($urandom_range(8'h9F, 8'h80)));
        push_byte(rand_trail());
      end
      3: begin
        push_byte(8'hED);
        push_byte(8'($urandom_range(8'hBF, 8'hA0)));
        push_byte(rand_trail());
      end
      4: begin
        push_byte(8'hF4);
        push_byte(8'($urandom_range(8'hBF, 8'h90)));
        push_byte(rand_trail());
        push_byte(rand_trail());
      end
      default: begin
        if ($urandom_range(1) == 0) push_byte(8'($urandom_range(8'hFF, 8'hF5)));
        else push_byte(rand_trail());
      end
    endcase
  endtask

  task automatic gen_text(input int n);
    int stop_at;
    int pick;
    int len;
    stop_at = bytes_queued + n;
    while (bytes_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        repeat (len) push_byte(rand_alnum());
      end else if (pick < 50) begin
        push_byte(rand_sep());
      end else if (pick < 68) begin
        push_cp(rand_cjk());
      end else if (pick < 78) begin
        push_cp(rand_cp());
      end else if (pick < 90) begin
        push_broken();
      end else begin
        push_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(24) == 0) byte_q[$].last = 1'b1;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [TOKEN_LEN_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_LOWERCASE) lc_en = val[0];
    else if (idx == CFG_MAX_LEN) max_len = val;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (bytes_sent != bytes_queued || scan_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------- driver ----------------
  always @(negedge clk) begin : driver
    text_item_t it;
    logic       nv;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      byte_taken = 1'b0;
      nv         = 1'b0;
      if (draining && scan_q.size() == 0) draining = 1'b0;
      if (!draining && byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it         = byte_q.pop_front();
        nv         = 1'b1;
        draining   = it.drain_after;
        data_byte <= it.b;
        last_byte <= it.last;
      end
      in_valid <= nv;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      hold_left  = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------- accept and monitor ----------------
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      scan_q.push_back(tokenize_byte(data_byte, last_byte));
      bytes_sent++;
      byte_taken = 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    scan_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (scan_q.size() == 0) begin
        $error("result item with no byte outstanding");
        errors++;
      end else begin
        exp_r = scan_q.pop_front();
        check_field("out_byte", 32'(exp_r.echo), 32'(out_byte));
        check_field("token_valid", 32'(exp_r.tok_valid), 32'(token_valid));
        check_field("token_start", 32'(exp_r.tok_start), 32'(token_start));
        check_field("token_length", 32'(exp_r.tok_len), 32'(token_length));
        check_field("token_kind", 32'(exp_r.tok_kind), 32'(token_kind));
        check_field("end_of_text", 32'(exp_r.eot), 32'(end_of_text));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // defaults kept; spare indexes must not touch either register
    write_reg(CFG_SPARE_2, 16'hFFFF);
    write_reg(CFG_SPARE_3, 16'h0000);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    push_byte(8'h41);
    push_byte(8'h62);
    push_byte(8'h39);
    push_byte(8'h20);
    push_byte(8'h00);
    push_cp(CJK_A_LO);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'hE4);
    push_byte(8'h20);
    push_cp(21'h1F600);
    push_cp(CJK_C_LO);
    push_cp(21'h00E9);
    push_byte(8'h5A);
    byte_q[$].last = 1'b1;
    // run ended by a lead byte that is then cut off by end of text
    push_byte(8'h7A);
    push_byte(8'hE5);
    byte_q[$].last = 1'b1;
    wait_idle();

    write_reg(CFG_LOWERCASE, 16'd1);
    write_reg(CFG_MAX_LEN, 16'd3);
    send_idle_pct  = 8;
    recv_stall_pct = 88;
    gen_text(240);
    wait_idle();

    write_reg(CFG_LOWERCASE, 16'd0);
    write_reg(CFG_MAX_LEN, 16'd0);
    send_idle_pct  = 88;
    recv_stall_pct = 8;
    gen_text(240);
    wait_idle();

    write_reg(CFG_LOWERCASE, 16'd1);
    write_reg(CFG_MAX_LEN, 16'hFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    gen_text(120);
    byte_q[$].drain_after = 1'b1;
    gen_text(120);
    byte_q[$].last = 1'b1;
    wait_idle();

    write_reg(CFG_LOWERCASE, 16'd0);
    write_reg(CFG_MAX_LEN, 16'd1);
    gen_text(230);
    wait_idle();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
